// File: src/clr_pkg.sv
package clr_pkg;

  localparam int MAX_PTS = 4096;
  localparam int ADDR_W  = $clog2(MAX_PTS);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int FRAC    = 16;
  localparam int LEN_W   = 48;
  localparam int PC_W    = 11;
  localparam int IDX_W   = 10;
  localparam int CRD_W   = 16;

  localparam logic [PC_W-1:0] PC_RESET = PC_W'(239);

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OPEN = 2'd1;
  localparam logic [1:0] ST_IDX  = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  typedef struct packed {
    logic latch;
    logic clear;
    logic set_ovf;
    logic store;
    logic store_add;
    logic sqrt_seg;
    logic sqrt_close;
    logic add_close;
    logic req_check;
    logic mul_t;
    logic div_t;
    logic load_t;
    logic read_mid;
    logic search_step;
    logic read_j0;
    logic latch_j0;
    logic read_j1;
    logic latch_j1;
    logic seg_calc;
    logic idiff;
    logic imul;
    logic div_i;
    logic round;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic first;
    logic last;
    logic closed;
    logic full;
    logic empty;
    logic bad;
    logic trivial;
    logic sq_busy;
    logic dv_busy;
    logic t_zero;
    logic search_more;
    logic lo_zero;
    logic seg_zero;
    logic axis;
    logic out_free;
  } sts_t;

endpackage

// File: src/clr_if.sv
interface clr_req_if;
  import clr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic signed [CRD_W-1:0] point_x;
  logic signed [CRD_W-1:0] point_y;
  logic                    first_point;
  logic                    last_point;
  logic [IDX_W-1:0]        out_index;
  modport source (output valid, mode, point_x, point_y, first_point, last_point, out_index,
                  input ready);
  modport sink (input valid, mode, point_x, point_y, first_point, last_point, out_index,
                output ready);
endinterface

interface clr_rsp_if;
  import clr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] res_x;
  logic signed [CRD_W-1:0] res_y;
  logic [1:0]              status;
  modport source (output valid, res_x, res_y, status, input ready);
  modport sink (input valid, res_x, res_y, status, output ready);
endinterface

// File: src/clr_ctrl.sv
module clr_ctrl
  import clr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_LOAD, S_SQRT_SEG, S_CLOSE_START, S_SQRT_CLOSE,
    S_TDIV_START, S_TDIV, S_TCHK, S_SEARCH, S_SEARCH_WAIT, S_FETCH1, S_FETCH2,
    S_SEG, S_SEGCHK, S_IDIFF, S_IMUL, S_IDIV, S_ROUND, S_RESP
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!sts.mode) begin
          if (sts.first) begin
            cmd.clear = 1'b1;
            state_next = S_LOAD;
          end else if (sts.closed) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_LOAD;
          end
        end else begin
          cmd.req_check = 1'b1;
          cmd.mul_t = 1'b1;
          if (sts.bad || sts.trivial) state_next = S_RESP;
          else state_next = S_TDIV_START;
        end
      end
      S_LOAD: begin
        if (sts.full) begin
          cmd.set_ovf = 1'b1;
          state_next = sts.last ? S_CLOSE_START : S_IDLE;
        end else if (sts.empty) begin
          cmd.store = 1'b1;
          state_next = sts.last ? S_CLOSE_START : S_IDLE;
        end else begin
          cmd.sqrt_seg = 1'b1;
          state_next = S_SQRT_SEG;
        end
      end
      S_SQRT_SEG: begin
        if (!sts.sq_busy) begin
          cmd.store = 1'b1;
          cmd.store_add = 1'b1;
          state_next = sts.last ? S_CLOSE_START : S_IDLE;
        end
      end
      S_CLOSE_START: begin
        cmd.sqrt_close = 1'b1;
        state_next = S_SQRT_CLOSE;
      end
      S_SQRT_CLOSE: begin
        if (!sts.sq_busy) begin
          cmd.add_close = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TDIV_START: begin
        cmd.div_t = 1'b1;
        state_next = S_TDIV;
      end
      S_TDIV: begin
        if (!sts.dv_busy) begin
          cmd.load_t = 1'b1;
          state_next = S_TCHK;
        end
      end
      S_TCHK: begin
        state_next = sts.t_zero ? S_RESP : S_SEARCH;
      end
      S_SEARCH: begin
        if (sts.search_more) begin
          cmd.read_mid = 1'b1;
          state_next = S_SEARCH_WAIT;
        end else if (sts.lo_zero) begin
          state_next = S_RESP;
        end else begin
          cmd.read_j0 = 1'b1;
          state_next = S_FETCH1;
        end
      end
      S_SEARCH_WAIT: begin
        cmd.search_step = 1'b1;
        state_next = S_SEARCH;
      end
      S_FETCH1: begin
        cmd.latch_j0 = 1'b1;
        cmd.read_j1 = 1'b1;
        state_next = S_FETCH2;
      end
      S_FETCH2: begin
        cmd.latch_j1 = 1'b1;
        state_next = S_SEG;
      end
      S_SEG: begin
        cmd.seg_calc = 1'b1;
        state_next = S_SEGCHK;
      end
      S_SEGCHK: begin
        state_next = sts.seg_zero ? S_RESP : S_IDIFF;
      end
      S_IDIFF: begin
        cmd.idiff = 1'b1;
        state_next = S_IMUL;
      end
      S_IMUL: begin
        cmd.imul = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.div_i = 1'b1;
        state_next = S_IDIV;
      end
      S_IDIV: begin
        if (!sts.dv_busy) begin
          cmd.round = 1'b1;
          state_next = sts.axis ? S_RESP : S_IDIFF;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// File: src/clr_dp.sv
module clr_dp
  import clr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic                    cfg_we,
  input  logic [PC_W-1:0]         cfg_data,
  input  logic                    in_mode,
  input  logic signed [CRD_W-1:0] in_x,
  input  logic signed [CRD_W-1:0] in_y,
  input  logic                    in_first,
  input  logic                    in_last,
  input  logic [IDX_W-1:0]        in_index,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [CRD_W-1:0] out_x,
  output logic signed [CRD_W-1:0] out_y,
  output logic [1:0]              out_status
);

  localparam int RT_W  = 17 + FRAC;       // root bits
  localparam int D2_W  = 34;
  localparam int REM_W = RT_W + 4;
  localparam int PR_W  = IDX_W + LEN_W;
  localparam int DV_W  = 65;
  localparam int IQ_W  = 17;
  localparam int CT_W  = 7;

  logic [PC_W-1:0] point_count;

  // latched item
  logic                    mode, first, last;
  logic signed [CRD_W-1:0] ix, iy;
  logic [IDX_W-1:0]        idx;

  // contour state
  logic [CNT_W-1:0]        stored;
  logic [LEN_W-1:0]        running;
  logic                    closed, ovf;
  logic signed [CRD_W-1:0] prev_x, prev_y, fst_x, fst_y;

  logic [2*CRD_W-1:0] pt_mem  [MAX_PTS];
  logic [LEN_W-1:0]   cum_mem [MAX_PTS];
  logic [2*CRD_W-1:0] rd_pt;
  logic [LEN_W-1:0]   rd_cum;
  logic [ADDR_W-1:0]  rd_addr;

  // sqrt unit
  logic [D2_W-1:0]  sq_d2;
  logic [REM_W-1:0] sq_rem;
  logic [RT_W-1:0]  sq_root;
  logic [5:0]       sq_k;
  logic             sq_busy;

  // divider
  logic [DV_W-1:0]  dv_dvd;
  logic [LEN_W-1:0] dv_r, dv_den, dv_q;
  logic [CT_W-1:0]  dv_cnt;
  logic             dv_busy;

  // request
  logic [PR_W-1:0]         prod;
  logic [LEN_W-1:0]        t, c0, c1, seg, off;
  logic [CNT_W-1:0]        lo, hi;
  logic signed [CRD_W-1:0] p0x, p0y, p1x, p1y;
  logic signed [CRD_W:0]   dd;
  logic [DV_W-1:0]         num;
  logic                    axis;
  logic signed [CRD_W-1:0] rx, ry;
  logic [1:0]              rstat;

  // sqrt operands
  logic signed [CRD_W-1:0] sa_x, sa_y, sb_x, sb_y;
  logic signed [CRD_W:0]   sdx, sdy;
  logic [CRD_W:0]          sax, say;
  logic [D2_W-1:0]         d2_new;
  logic [REM_W-1:0]        rem_sh;
  logic [REM_W-1:0]        trial;

  always_comb begin
    if (cmd.sqrt_close) begin
      sa_x = prev_x; sa_y = prev_y; sb_x = fst_x; sb_y = fst_y;
    end else begin
      sa_x = prev_x; sa_y = prev_y; sb_x = ix; sb_y = iy;
    end
    sdx = (CRD_W+1)'(sb_x) - (CRD_W+1)'(sa_x);
    sdy = (CRD_W+1)'(sb_y) - (CRD_W+1)'(sa_y);
    sax = sdx[CRD_W] ? (CRD_W+1)'(-sdx) : sdx;
    say = sdy[CRD_W] ? (CRD_W+1)'(-sdy) : sdy;
    d2_new = D2_W'(sax) * D2_W'(sax) + D2_W'(say) * D2_W'(say);
    rem_sh = {sq_rem[REM_W-3:0], sq_d2[D2_W-1:D2_W-2]};
    trial = REM_W'({sq_root, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
    end else if (cmd.sqrt_seg || cmd.sqrt_close) begin
      sq_d2 <= d2_new;
      sq_rem <= '0;
      sq_root <= '0;
      sq_k <= 6'(RT_W - 1);
      sq_busy <= 1'b1;
    end else if (sq_busy) begin
      sq_d2 <= {sq_d2[D2_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        sq_rem <= rem_sh - trial;
        sq_root <= {sq_root[RT_W-2:0], 1'b1};
      end else begin
        sq_rem <= rem_sh;
        sq_root <= {sq_root[RT_W-2:0], 1'b0};
      end
      if (sq_k == '0) sq_busy <= 1'b0;
      else sq_k <= sq_k - 6'd1;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [LEN_W:0] dv_sh;
  assign dv_sh = {dv_r, dv_dvd[DV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
    end else if (cmd.div_t) begin
      dv_dvd <= {prod, (DV_W-PR_W)'(0)};
      dv_r <= '0;
      dv_den <= LEN_W'(point_count);
      dv_q <= '0;
      dv_cnt <= CT_W'(PR_W - 1);
      dv_busy <= 1'b1;
    end else if (cmd.div_i) begin
      dv_dvd <= {num[IQ_W-1:0], (DV_W-IQ_W)'(0)};
      dv_r <= num[DV_W-1:IQ_W];
      dv_den <= seg;
      dv_q <= '0;
      dv_cnt <= CT_W'(IQ_W - 1);
      dv_busy <= 1'b1;
    end else if (dv_busy) begin
      dv_dvd <= {dv_dvd[DV_W-2:0], 1'b0};
      if (dv_sh >= {1'b0, dv_den}) begin
        dv_r <= LEN_W'(dv_sh - {1'b0, dv_den});
        dv_q <= {dv_q[LEN_W-2:0], 1'b1};
      end else begin
        dv_r <= dv_sh[LEN_W-1:0];
        dv_q <= {dv_q[LEN_W-2:0], 1'b0};
      end
      if (dv_cnt == '0) dv_busy <= 1'b0;
      else dv_cnt <= dv_cnt - CT_W'(1);
    end
  end

  // saturating perimeter adds
  logic [LEN_W:0]   sum_full;
  logic [LEN_W-1:0] sum_sat, cum_w;
  always_comb begin
    sum_full = {1'b0, running} + (LEN_W+1)'(sq_root);
    sum_sat = sum_full[LEN_W] ? '1 : sum_full[LEN_W-1:0];
    cum_w = cmd.store_add ? sum_sat : running;
  end

  // memories
  logic [CNT_W:0] mid_sum;
  logic [CNT_W-1:0] mid, lo_m1;
  always_comb begin
    mid_sum = {1'b0, lo} + {1'b0, hi};
    mid = mid_sum[CNT_W:1];
    lo_m1 = lo - CNT_W'(1);
    if (cmd.read_j0) rd_addr = lo_m1[ADDR_W-1:0];
    else if (cmd.read_j1) rd_addr = lo[ADDR_W-1:0];
    else rd_addr = mid[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      pt_mem[stored[ADDR_W-1:0]] <= {ix, iy};
      cum_mem[stored[ADDR_W-1:0]] <= cum_w;
    end
    rd_pt <= pt_mem[rd_addr];
    rd_cum <= cum_mem[rd_addr];
  end

  // contour control state
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= PC_RESET;
      stored <= '0;
      running <= '0;
      closed <= 1'b0;
      ovf <= 1'b0;
    end else begin
      if (cfg_we) point_count <= cfg_data;
      if (cmd.clear) begin
        stored <= '0;
        running <= '0;
        closed <= 1'b0;
        ovf <= 1'b0;
      end
      if (cmd.set_ovf) ovf <= 1'b1;
      if (cmd.store) begin
        stored <= stored + CNT_W'(1);
        running <= cum_w;
      end
      if (cmd.add_close) begin
        running <= sum_sat;
        closed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode <= in_mode;
      ix <= in_x;
      iy <= in_y;
      first <= in_first;
      last <= in_last;
      idx <= in_index;
    end
    if (cmd.store) begin
      prev_x <= ix;
      prev_y <= iy;
      if (stored == '0) begin
        fst_x <= ix;
        fst_y <= iy;
      end
    end
  end

  // request datapath
  logic                    bad_open, bad_idx;
  logic signed [CRD_W-1:0] pa, pb;
  logic [CRD_W-1:0]        ad;
  logic [IQ_W-1:0]         q;
  logic signed [CRD_W+1:0] base, rnd;
  logic [LEN_W-1:0]        fr;
  logic [LEN_W:0]          twofr;
  logic                    up;
  logic [CNT_W-1:0]        n_lo;

  always_comb begin
    bad_open = !closed || (stored == '0);
    bad_idx = PC_W'(idx) >= point_count;
    pa = axis ? p0y : p0x;
    pb = axis ? p1y : p1x;
    ad = dd[CRD_W] ? CRD_W'(-dd) : dd[CRD_W-1:0];
    q = dv_q[IQ_W-1:0];
    if (!dd[CRD_W]) begin
      base = (CRD_W+2)'(pa) + (CRD_W+2)'(q);
      fr = dv_r;
    end else begin
      base = (CRD_W+2)'(pa) - (CRD_W+2)'(q) - ((dv_r != '0) ? (CRD_W+2)'(1) : '0);
      fr = (dv_r != '0) ? seg - dv_r : '0;
    end
    twofr = {fr, 1'b0};
    up = (twofr > {1'b0, seg}) ||
         ((twofr == {1'b0, seg}) && (fr != '0) && base[0]);
    rnd = base + (up ? (CRD_W+2)'(1) : '0);
    n_lo = lo;
  end

  always_ff @(posedge clk) begin
    if (cmd.req_check) begin
      axis <= 1'b0;
      if (bad_open || bad_idx) begin
        rx <= '0;
        ry <= '0;
        rstat <= bad_open ? ST_OPEN : ST_IDX;
      end else begin
        rx <= fst_x;
        ry <= fst_y;
        rstat <= ovf ? ST_OVF : ST_OK;
      end
    end
    if (cmd.mul_t) prod <= PR_W'(idx) * PR_W'(running);
    if (cmd.load_t) begin
      t <= dv_q;
      lo <= '0;
      hi <= stored;
    end
    if (cmd.search_step) begin
      if (rd_cum >= t) hi <= mid;
      else lo <= mid + CNT_W'(1);
    end
    if (cmd.latch_j0) begin
      c0 <= rd_cum;
      p0x <= rd_pt[2*CRD_W-1:CRD_W];
      p0y <= rd_pt[CRD_W-1:0];
    end
    if (cmd.latch_j1) begin
      if (n_lo < stored) begin
        c1 <= rd_cum;
        p1x <= rd_pt[2*CRD_W-1:CRD_W];
        p1y <= rd_pt[CRD_W-1:0];
      end else begin
        c1 <= running;
        p1x <= fst_x;
        p1y <= fst_y;
      end
    end
    if (cmd.seg_calc) begin
      seg <= c1 - c0;
      off <= t - c0;
    end
    if (cmd.idiff) dd <= (CRD_W+1)'(pb) - (CRD_W+1)'(pa);
    if (cmd.imul) num <= DV_W'(off) * DV_W'(ad);
    if (cmd.round) begin
      if (axis) ry <= rnd[CRD_W-1:0];
      else rx <= rnd[CRD_W-1:0];
      axis <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_x <= rx;
      out_y <= ry;
      out_status <= rstat;
    end
  end

  always_comb begin
    sts.mode = mode;
    sts.first = first;
    sts.last = last;
    sts.closed = closed;
    sts.full = stored >= CNT_W'(MAX_PTS);
    sts.empty = (stored == '0);
    sts.bad = bad_open || bad_idx;
    sts.trivial = (idx == '0) || (running == '0);
    sts.sq_busy = sq_busy;
    sts.dv_busy = dv_busy;
    sts.t_zero = (t == '0);
    sts.search_more = lo < hi;
    sts.lo_zero = (lo == '0);
    sts.seg_zero = (seg == '0);
    sts.axis = axis;
    sts.out_free = !out_valid || out_ready;
  end

endmodule

// File: src/contour_arc_length_resampler.sv
// channel | role  | payload
// req     | sink  | mode, point_x, point_y, first_point, last_point, out_index
// rsp     | source| res_x, res_y, status
// cfg     | write | point_count (cfg_we, cfg_data)
//
// a load that adds a segment waits on the 33-step bit-serial square root, and one that
// also closes the contour runs it a second time
// a request waits on the binary search over the stored points and on the
// restoring divider (58 steps for the target, 17 per interpolated axis)
// one item is in work at a time; a finished request waits in the output register
// rst is synchronous, active high; it empties the contour and sets point_count to 239
module contour_arc_length_resampler
  import clr_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  clr_req_if.sink         req,
  clr_rsp_if.source       rsp,
  input  logic            cfg_we,
  input  logic [PC_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  clr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  clr_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_mode    (req.mode),
    .in_x       (req.point_x),
    .in_y       (req.point_y),
    .in_first   (req.first_point),
    .in_last    (req.last_point),
    .in_index   (req.out_index),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_x      (rsp.res_x),
    .out_y      (rsp.res_y),
    .out_status (rsp.status)
  );

endmodule

// File: dv/tb_top.sv
module tb_top;
  import clr_pkg::*;

  typedef struct {
    logic              mode;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic              first;
    logic              last;
    logic [IDX_W-1:0]  idx;
  } item_t;

  typedef struct {
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic [1:0]         status;
  } point_res_t;

  localparam longint unsigned LEN_SAT = (64'd1 << LEN_W) - 1;
  localparam int DRAIN_CYCLES = 300;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [PC_W-1:0] cfg_data;

  clr_req_if req_ch();
  clr_rsp_if rsp_ch();

  contour_arc_length_resampler DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  item_t pend_q[$];
  point_res_t resampled_q[$];
  int errors = 0;

  int send_idle = 0;
  int recv_idle = 0;
  bit hold_send = 0;
  int stall_reqs = 0;
  int stall_seen = 0;
  int stall_cnt = 0;

  // contour mirror
  logic signed [15:0] cx[MAX_PTS];
  logic signed [15:0] cy[MAX_PTS];
  longint unsigned cum[MAX_PTS];
  int npts = 0;
  longint unsigned perim = 0;
  bit closed = 0;
  bit ovf = 0;
  int pc = 239;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned seg_len(longint x1, longint y1, longint x2, longint y2);
    longint dx, dy;
    longint unsigned d2, root, rem, pair, trial;
    dx = x2 - x1;
    dy = y2 - y1;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    d2 = dx * dx + dy * dy;
    root = 0;
    rem = 0;
    for (int k = 16 + FRAC; k >= 0; k--) begin
      pair = 0;
      if (k >= FRAC) pair = (d2 >> (2 * (k - FRAC))) & 3;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > LEN_SAT) ? LEN_SAT : s;
  endfunction

  // linear blend, round half to even
  function automatic longint lerp_round(longint a, longint b, longint unsigned off,
                                        longint unsigned seg);
    longint d, base;
    longint unsigned ad, num, q, r, fr;
    d = b - a;
    ad = (d < 0) ? -d : d;
    num = off * ad;
    q = num / seg;
    r = num % seg;
    if (d >= 0) begin
      base = a + longint'(q);
      fr = r;
    end else begin
      base = a - longint'(q) - ((r > 0) ? 1 : 0);
      fr = (r > 0) ? seg - r : 0;
    end
    if (2 * fr > seg || (2 * fr == seg && fr != 0 && base[0])) base = base + 1;
    return base;
  endfunction

  task automatic apply_item(item_t it);
    point_res_t res;
    longint unsigned t, c0, c1, seg;
    int lo, hi, mid, j0, j1;
    if (it.mode == 1'b0) begin
      if (it.first) begin
        npts = 0;
        perim = 0;
        closed = 0;
        ovf = 0;
      end else if (closed) begin
        return;
      end
      if (npts >= MAX_PTS) begin
        ovf = 1;
      end else begin
        if (npts > 0) perim = sat_sum(perim, seg_len(cx[npts-1], cy[npts-1], it.x, it.y));
        cx[npts] = it.x;
        cy[npts] = it.y;
        cum[npts] = perim;
        npts++;
      end
      if (it.last) begin
        perim = sat_sum(perim, seg_len(cx[npts-1], cy[npts-1], cx[0], cy[0]));
        closed = 1;
      end
      return;
    end
    res.rx = 0;
    res.ry = 0;
    if (!closed || npts == 0) begin
      res.status = ST_OPEN;
    end else if (it.idx >= pc) begin
      res.status = ST_IDX;
    end else begin
      res.status = ovf ? ST_OVF : ST_OK;
      res.rx = cx[0];
      res.ry = cy[0];
      if (it.idx != 0 && perim != 0) begin
        t = longint'(it.idx) * perim / longint'(pc);
        if (t > 0) begin
          lo = 0;
          hi = npts;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (cum[mid] >= t) hi = mid;
            else lo = mid + 1;
          end
          if (lo > 0) begin
            j0 = lo - 1;
            j1 = (lo < npts) ? lo : 0;
            c0 = cum[j0];
            c1 = (lo < npts) ? cum[lo] : perim;
            seg = c1 - c0;
            if (seg > 0) begin
              res.rx = 16'(lerp_round(cx[j0], cx[j1], t - c0, seg));
              res.ry = 16'(lerp_round(cy[j0], cy[j1], t - c0, seg));
            end
          end
        end
      end
    end
    resampled_q.insert(resampled_q.size(), res);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        item_t cur;
        cur.mode = req_ch.mode;
        cur.x = req_ch.point_x;
        cur.y = req_ch.point_y;
        cur.first = req_ch.first_point;
        cur.last = req_ch.last_point;
        cur.idx = req_ch.out_index;
        apply_item(cur);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pend_q.size() > 0 && !hold_send && $urandom_range(99) >= send_idle) begin
          item_t nx;
          nx = pend_q.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.mode <= nx.mode;
          req_ch.point_x <= nx.x;
          req_ch.point_y <= nx.y;
          req_ch.first_point <= nx.first;
          req_ch.last_point <= nx.last;
          req_ch.out_index <= nx.idx;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with a single long hold-off
  always @(posedge clk) begin
    if (stall_reqs != stall_seen) begin
      stall_seen <= stall_reqs;
      stall_cnt <= 4000;
      rsp_ch.ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (resampled_q.size() == 0) begin
        $error("unexpected result x=%0d y=%0d status=%0d",
               rsp_ch.res_x, rsp_ch.res_y, rsp_ch.status);
        errors++;
      end else begin
        point_res_t e;
        e = resampled_q.pop_front();
        if (rsp_ch.res_x !== e.rx) begin
          $error("res_x expected %0d actual %0d", e.rx, rsp_ch.res_x);
          errors++;
        end
        if (rsp_ch.res_y !== e.ry) begin
          $error("res_y expected %0d actual %0d", e.ry, rsp_ch.res_y);
          errors++;
        end
        if (rsp_ch.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, rsp_ch.status);
          errors++;
        end
      end
    end
  end

  task automatic push_load(logic signed [15:0] x, logic signed [15:0] y, bit f, bit l);
    item_t it;
    it.mode = 1'b0;
    it.x = x;
    it.y = y;
    it.first = f;
    it.last = l;
    it.idx = IDX_W'($urandom);
    pend_q.insert(pend_q.size(), it);
  endtask

  task automatic push_req(int idx);
    item_t it;
    it.mode = 1'b1;
    it.x = 16'($urandom);
    it.y = 16'($urandom);
    it.first = 1'($urandom);
    it.last = 1'($urandom);
    it.idx = IDX_W'(idx);
    pend_q.insert(pend_q.size(), it);
  endtask

  function automatic logic signed [15:0] rand_coord(int spread);
    case (spread)
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(200)) - 100);
      default: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  task automatic push_contour(int n);
    int spread;
    logic signed [15:0] x0, y0;
    spread = $urandom_range(2);
    x0 = rand_coord(spread);
    y0 = rand_coord(spread);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) push_load(x0, y0, i == 0, i == n - 1);
      else push_load(rand_coord(spread), rand_coord(spread), i == 0, i == n - 1);
    end
  endtask

  task automatic wait_idle();
    while (pend_q.size() != 0 || req_ch.valid || resampled_q.size() != 0) @(posedge clk);
    // a trailing load may still be in work
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= PC_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    pc = v;
  endtask

  task automatic random_items(int budget);
    int cnt;
    int n;
    cnt = 0;
    while (cnt < budget) begin
      if ($urandom_range(99) < 75) begin
        n = ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        push_contour(n);
        cnt += n;
        for (int k = $urandom_range(1, 6); k > 0; k--) begin
          push_req(($urandom_range(7) == 0) ? $urandom_range(1023) : $urandom_range(pc - 1));
          cnt++;
        end
      end else if ($urandom_range(1)) begin
        push_load(16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
        cnt++;
      end else begin
        push_req($urandom_range(1023));
        cnt++;
      end
    end
  endtask

  initial begin
    int counts[6];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.mode = 1'b0;
    req_ch.point_x = '0;
    req_ch.point_y = '0;
    req_ch.first_point = 1'b0;
    req_ch.last_point = 1'b0;
    req_ch.out_index = '0;
    rsp_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: open contour, extremes, degenerate shapes, ignored loads
    push_req(0);
    push_load(16'sh8000, 16'sh8000, 1, 0);
    push_load(16'sh7fff, 16'sh8000, 0, 0);
    push_req(5);
    push_load(16'sh7fff, 16'sh7fff, 0, 0);
    push_load(16'sh8000, 16'sh7fff, 0, 1);
    push_load(16'sd3, 16'sd3, 0, 0);
    push_req(0);
    push_req(1);
    push_req(60);
    push_req(238);
    push_req(239);
    push_req(1023);
    push_load(16'sd7, -16'sd9, 1, 1);
    push_req(100);
    push_load(16'sd4, 16'sd4, 1, 0);
    push_load(16'sd4, 16'sd4, 0, 0);
    push_load(16'sd4, 16'sd4, 0, 1);
    push_req(17);
    push_load(16'sd0, 16'sd0, 1, 0);
    push_load(16'sd1, 16'sd0, 0, 1);
    push_req(1);
    push_req(120);
    wait_idle();

    // overflowed contour
    for (int i = 0; i <= MAX_PTS; i++)
      push_load(16'(int'($urandom_range(40)) - 20), 16'(int'($urandom_range(40)) - 20),
                i == 0, i == MAX_PTS);
    push_req(0);
    push_req(77);
    push_req(238);
    wait_idle();

    counts = '{1, 1024, 7, 0, 239, 0};
    for (int p = 0; p < 6; p++) begin
      set_count(counts[p] == 0 ? $urandom_range(1, 1024) : counts[p]);
      case (p % 4)
        0: begin send_idle = 0; recv_idle = 0; end
        1: begin send_idle = 73; recv_idle = 0; end
        2: begin send_idle = 0; recv_idle = 73; end
        default: begin send_idle = 12; recv_idle = 12; end
      endcase
      if (p == 2) begin
        send_idle = 0;
        recv_idle = 0;
        push_contour(5);
        for (int k = 0; k < 40; k++) push_req($urandom_range(pc - 1));
        stall_reqs++;
        random_items(200);
        wait_idle();
        recv_idle = 73;
      end
      if (p == 3) begin
        random_items(20);
        hold_send = 1;
        while (req_ch.valid || resampled_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        hold_send = 0;
      end
      random_items(220);
      wait_idle();
    end

    if (errors == 0 && resampled_q.size() == 0) begin
      $display("[contour_arc_length_resampler] OK");
    end else begin
      $display("[contour_arc_length_resampler] ERROR");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("[contour_arc_length_resampler] ERROR");
    $finish;
  end

endmodule
